// ----- design/tps_pkg.sv -----
// Shared types, byte codes and helpers for the text paragraph statistics core.
`timescale 1ns / 1ps

package tps_pkg;

  // Default width of the internal saturating counters.
  localparam int COUNT_WIDTH_DEFAULT = 32;

  // Width of every count field on the result channel.
  localparam int OUT_WIDTH = 32;

  // Register indexes of the configuration port.
  localparam logic REG_COUNT_SPACES         = 1'b0;
  localparam logic REG_COUNT_SENTENCE_MARKS = 1'b1;

  // Byte codes that the classifier recognizes.
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [7:0] CHAR_EXCLAIM  = 8'h21;

  // Newline run value at which a paragraph break is pending.
  localparam logic [1:0] NEWLINE_BREAK = 2'd2;

  typedef enum logic [2:0] {
    BC_NEWLINE,
    BC_SPACE,
    BC_TAB,
    BC_MARK,
    BC_WORD
  } byte_class_t;

  // Per-transfer commands from the text tracker to the counter bank.
  typedef struct packed {
    logic end_text;      // add one sentence, close final paragraph, clear all
    logic close_para;    // close paragraph before the word that starts now
    logic add_char;
    logic add_word;
    logic add_sentence;
  } ctrl_t;

  // One paragraph record as it leaves the core.
  typedef struct packed {
    logic [OUT_WIDTH-1:0] para_chars;
    logic [OUT_WIDTH-1:0] para_words;
    logic [OUT_WIDTH-1:0] para_sentences;
    logic [OUT_WIDTH-1:0] total_chars;
    logic [OUT_WIDTH-1:0] total_words;
    logic [OUT_WIDTH-1:0] total_sentences;
    logic [OUT_WIDTH-1:0] total_paragraphs;
    logic                 final_record;
  } rec_t;

  // Sort a text byte into the classes that drive the word tracker.
  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    case (b) inside
      CHAR_NEWLINE:                             c = BC_NEWLINE;
      CHAR_SPACE:                               c = BC_SPACE;
      CHAR_TAB:                                 c = BC_TAB;
      CHAR_PERIOD, CHAR_QUESTION, CHAR_EXCLAIM: c = BC_MARK;
      default:                                  c = BC_WORD;
    endcase
    return c;
  endfunction

endpackage

// ----- design/tps_counters.sv -----
// Saturating paragraph and running-total counters with record formation.
`timescale 1ns / 1ps

module tps_counters #(
  parameter int COUNT_WIDTH = tps_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  tps_pkg::ctrl_t ctrl,
  output tps_pkg::rec_t  rec
);
  import tps_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  logic [COUNT_WIDTH-1:0] para_chars;
  logic [COUNT_WIDTH-1:0] para_words;
  logic [COUNT_WIDTH-1:0] para_sentences;
  logic [COUNT_WIDTH-1:0] total_chars;
  logic [COUNT_WIDTH-1:0] total_words;
  logic [COUNT_WIDTH-1:0] total_sentences;
  logic [COUNT_WIDTH-1:0] total_paras;

  logic [COUNT_WIDTH-1:0] chars_inc;
  logic [COUNT_WIDTH-1:0] words_inc;
  logic [COUNT_WIDTH-1:0] sentences_inc;
  logic [COUNT_WIDTH-1:0] rec_sentences;
  logic [COUNT_WIDTH-1:0] total_chars_next;
  logic [COUNT_WIDTH-1:0] total_words_next;
  logic [COUNT_WIDTH-1:0] total_sentences_next;
  logic [COUNT_WIDTH-1:0] total_paras_next;
  logic                   closing;

  // Add one, holding at the top value.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] a);
    return (a == CNT_MAX) ? a : a + CNT_ONE;
  endfunction

  // Add two counts, holding at the top value on carry out.
  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [COUNT_WIDTH-1:0] b);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];
  endfunction

  // Keep the low bits of a counter for a result field, zero-extending narrow ones.
  function automatic logic [OUT_WIDTH-1:0] fit_out(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+OUT_WIDTH-1:0] ext;
    ext = {{OUT_WIDTH{1'b0}}, v};
    return ext[OUT_WIDTH-1:0];
  endfunction

  // Incremented values and the totals that a closing paragraph produces.
  always_comb begin
    chars_inc            = sat_inc(para_chars);
    words_inc            = sat_inc(para_words);
    sentences_inc        = sat_inc(para_sentences);
    rec_sentences        = ctrl.end_text ? sentences_inc : para_sentences;
    closing              = ctrl.end_text | ctrl.close_para;
    total_chars_next     = sat_add(total_chars, para_chars);
    total_words_next     = sat_add(total_words, para_words);
    total_sentences_next = sat_add(total_sentences, rec_sentences);
    total_paras_next     = sat_inc(total_paras);
  end

  // Record as seen on the transfer that closes a paragraph.
  always_comb begin
    rec.para_chars       = fit_out(para_chars);
    rec.para_words       = fit_out(para_words);
    rec.para_sentences   = fit_out(rec_sentences);
    rec.total_chars      = fit_out(total_chars_next);
    rec.total_words      = fit_out(total_words_next);
    rec.total_sentences  = fit_out(total_sentences_next);
    rec.total_paragraphs = fit_out(total_paras_next);
    rec.final_record     = ctrl.end_text;
  end

  // Counter updates; a word that closes a paragraph starts the next one at one.
  always_ff @(posedge clk) begin
    if (rst || ctrl.end_text) begin
      para_chars      <= '0;
      para_words      <= '0;
      para_sentences  <= '0;
      total_chars     <= '0;
      total_words     <= '0;
      total_sentences <= '0;
      total_paras     <= '0;
    end else if (closing) begin
      para_chars      <= CNT_ONE;
      para_words      <= CNT_ONE;
      para_sentences  <= '0;
      total_chars     <= total_chars_next;
      total_words     <= total_words_next;
      total_sentences <= total_sentences_next;
      total_paras     <= total_paras_next;
    end else begin
      if (ctrl.add_char) begin
        para_chars <= chars_inc;
      end
      if (ctrl.add_word) begin
        para_words <= words_inc;
      end
      if (ctrl.add_sentence) begin
        para_sentences <= sentences_inc;
      end
    end
  end

endmodule

// ----- design/text_paragraph_statistics_core.sv -----
// Top level of the text paragraph statistics core: word tracker and output register.
`timescale 1ns / 1ps

// Usage:
// Text enters one byte per transfer on the input channel (text_byte,
// end_of_text, in_valid/in_ready). A transfer with end_of_text set closes
// the text, produces a record flagged final_record and clears all counts.
// A word byte that follows two or more newlines closes the current
// paragraph and produces a record; every other transfer produces none.
// Records leave on the output channel (out_valid/out_ready) in the cycle after
// the input transfer that causes them, from a single output register.
// Throughput is one byte per cycle while in_ready is high; classification
// and counter updates for a byte fit between the tracker flags and counters.
// in_ready drops only while a record waits in the output register and the
// receiver is not taking it this cycle, so a stalled receiver holds input.
// Configuration (count_spaces, count_sentence_marks) is written through
// cfg_write/cfg_index/cfg_data while no text is in flight.
// Reset clears configuration, all counters and out_valid, but not out_rec.
module text_paragraph_statistics_core #(
  parameter int COUNT_WIDTH = tps_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_byte,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tps_pkg::OUT_WIDTH-1:0] para_chars,
  output logic [tps_pkg::OUT_WIDTH-1:0] para_words,
  output logic [tps_pkg::OUT_WIDTH-1:0] para_sentences,
  output logic [tps_pkg::OUT_WIDTH-1:0] total_chars,
  output logic [tps_pkg::OUT_WIDTH-1:0] total_words,
  output logic [tps_pkg::OUT_WIDTH-1:0] total_sentences,
  output logic [tps_pkg::OUT_WIDTH-1:0] total_paragraphs,
  output logic                          final_record
);
  import tps_pkg::*;

  logic        count_spaces;
  logic        count_sentence_marks;
  logic        inside_word;
  logic        inside_word_next;
  logic        mark_seen;
  logic        mark_seen_next;
  logic [1:0]  newline_run;
  logic [1:0]  newline_run_next;
  logic        in_fire;
  logic        rec_fire;
  byte_class_t cls;
  ctrl_t       ctrl;
  rec_t        rec;
  rec_t        out_rec;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cls      = classify(text_byte);
  assign rec_fire = ctrl.end_text || ctrl.close_para;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_spaces         <= 1'b0;
      count_sentence_marks <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COUNT_SPACES:         count_spaces         <= cfg_data;
        REG_COUNT_SENTENCE_MARKS: count_sentence_marks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Word tracking for one byte and the commands it sends to the counters.
  always_comb begin
    inside_word_next = inside_word;
    mark_seen_next   = mark_seen;
    newline_run_next = newline_run;
    ctrl             = '0;
    if (in_fire) begin
      if (end_of_text) begin
        ctrl.end_text    = 1'b1;
        inside_word_next = 1'b0;
        mark_seen_next   = 1'b0;
        newline_run_next = '0;
      end else begin
        case (cls) inside
          BC_NEWLINE, BC_SPACE, BC_TAB: begin
            // A blank ends the word; a sentence mark just before it ends a sentence.
            if (cls == BC_NEWLINE && newline_run != NEWLINE_BREAK) begin
              newline_run_next = newline_run + 2'd1;
            end
            ctrl.add_char     = (cls == BC_SPACE) && count_spaces;
            ctrl.add_sentence = inside_word && mark_seen;
            inside_word_next  = 1'b0;
            mark_seen_next    = 1'b0;
          end
          BC_MARK: begin
            mark_seen_next = 1'b1;
            ctrl.add_char  = count_sentence_marks;
          end
          default: begin
            if (!inside_word) begin
              ctrl.close_para  = (newline_run == NEWLINE_BREAK);
              ctrl.add_word    = 1'b1;
              newline_run_next = '0;
              inside_word_next = 1'b1;
            end
            ctrl.add_char  = 1'b1;
            mark_seen_next = 1'b0;
          end
        endcase
      end
    end
  end

  // Tracker flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word <= 1'b0;
      mark_seen   <= 1'b0;
      newline_run <= '0;
    end else begin
      inside_word <= inside_word_next;
      mark_seen   <= mark_seen_next;
      newline_run <= newline_run_next;
    end
  end

  tps_counters #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counters (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .rec  (rec)
  );

  // Output register: loads a record on the transfer that closes a paragraph.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= rec_fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && rec_fire) begin
      out_rec <= rec;
    end
  end

  assign para_chars       = out_rec.para_chars;
  assign para_words       = out_rec.para_words;
  assign para_sentences   = out_rec.para_sentences;
  assign total_chars      = out_rec.total_chars;
  assign total_words      = out_rec.total_words;
  assign total_sentences  = out_rec.total_sentences;
  assign total_paragraphs = out_rec.total_paragraphs;
  assign final_record     = out_rec.final_record;

endmodule

// ----- design/tps_checker.sv -----
// Port-level checks for the text paragraph statistics core, bound to the top level.
`timescale 1ns / 1ps

module tps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tps_pkg::OUT_WIDTH-1:0] para_chars,
  input logic                          final_record
);

  // Reset leaves no record pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("record pending after reset");

  // Input is held back only while a record waits and is not taken.
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output register");

  // A record appears only after an input transfer.
  a_record_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("record without an input transfer");

  // A stalled record stays valid and holds para_chars and final_record.
  a_record_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(para_chars) && $stable(final_record))
    else $error("stalled record changed");

endmodule

bind text_paragraph_statistics_core tps_checker u_tps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .para_chars   (para_chars),
  .final_record (final_record)
);
